// ----- src/bsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared constants, types and helpers for the barometric compensation unit.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TEMP_CAL   = 2'd0,
    CFG_PRESS_LOW  = 2'd1,
    CFG_PRESS_HIGH = 2'd2,
    CFG_PRESS_LAST = 2'd3
  } cfg_idx_e;

  localparam logic [31:0] POff   = 32'd64000;
  localparam logic [31:0] PBase  = 32'd1048576;
  localparam logic [31:0] PScale = 32'd3125;
  localparam logic [31:0] PHalf  = 32'h8000_0000;
  localparam logic [31:0] POne   = 32'd32768;
  localparam logic [31:0] TRnd   = 32'd128;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sra32(input logic [31:0] v, input int unsigned s);
    sra32 = 32'($signed(v) >>> s);
  endfunction

endpackage

// ----- src/bsc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_div
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bsc_div #(
  parameter int unsigned SideW = 96
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  logic [31:0]      num_i,
  input  logic [31:0]      den_i,
  input  logic [SideW-1:0] side_i,
  output logic             vld_o,
  output logic [31:0]      quo_o,
  output logic [SideW-1:0] side_o
);

  logic             vld_q  [33];
  logic [31:0]      num_q  [33];
  logic [31:0]      den_q  [33];
  logic [31:0]      rem_q  [33];
  logic [SideW-1:0] side_q [33];

  always_comb begin
    vld_q[0]  = vld_i;
    num_q[0]  = num_i;
    den_q[0]  = den_i;
    rem_q[0]  = '0;
    side_q[0] = side_i;
  end

  for (genvar k = 0; k < 32; k++) begin : g_stage
    logic [32:0] trial;
    logic [32:0] diff;
    assign trial = {rem_q[k], num_q[k][31]};
    assign diff  = trial - {1'b0, den_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (!diff[32]) begin
        rem_q[k+1] <= diff[31:0];
      end else begin
        rem_q[k+1] <= trial[31:0];
      end
      num_q[k+1]  <= {num_q[k][30:0], ~diff[32]};
      den_q[k+1]  <= den_q[k];
      side_q[k+1] <= side_q[k];
    end
  end

  assign vld_o  = vld_q[32];
  assign quo_o  = num_q[32];
  assign side_o = side_q[32];

endmodule

// ----- src/baro_sensor_compensation_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_sensor_compensation_unit
// Integer temperature and pressure compensation for a barometric sensor.
// ----------------------------------------------------------------------------
// Accepts one item per cycle (busy_o is always low) and returns each result,
// marked by done_o for one cycle. The datapath is built from 11 arithmetic
// stages plus a 32-stage pipelined divider and a final correction stage.
// The result cannot be stalled.
module baro_sensor_compensation_unit
  import bsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [19:0] raw_temp_i,
  input  logic [19:0] raw_press_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output logic        done_o,
  output logic [31:0] temp_centi_o,
  output logic [31:0] fine_temp_o,
  output logic [31:0] press_pa_o,
  output logic        press_invalid_o,
  output logic        temp_valid_o
);

  logic [47:0] tcal_q;
  logic [63:0] pcl_q, pch_q;
  logic [15:0] p9raw_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcal_q  <= '0;
      pcl_q   <= '0;
      pch_q   <= '0;
      p9raw_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TEMP_CAL:   tcal_q  <= cfg_data_i[47:0];
        CFG_PRESS_LOW:  pcl_q   <= cfg_data_i;
        CFG_PRESS_HIGH: pch_q   <= cfg_data_i;
        CFG_PRESS_LAST: p9raw_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = {16'd0, tcal_q[15:0]};
  assign t2 = sx16(tcal_q[31:16]);
  assign t3 = sx16(tcal_q[47:32]);
  assign p1 = {16'd0, pcl_q[15:0]};
  assign p2 = sx16(pcl_q[31:16]);
  assign p3 = sx16(pcl_q[47:32]);
  assign p4 = sx16(pcl_q[63:48]);
  assign p5 = sx16(pch_q[15:0]);
  assign p6 = sx16(pch_q[31:16]);
  assign p7 = sx16(pch_q[47:32]);
  assign p8 = sx16(pch_q[63:48]);
  assign p9 = sx16(p9raw_q);

  // S1: temperature products
  logic        v1_q, tv1_q;
  logic [19:0] ap1_q;
  logic [31:0] ta1_q, dd1_q;
  logic [31:0] at, dt;
  assign at = {12'd0, raw_temp_i};
  assign dt = (at >> 4) - t1;

  // S2
  logic        v2_q, tv2_q;
  logic [19:0] ap2_q;
  logic [31:0] ta2_q, tb2_q;
  // S3
  logic        v3_q, tv3_q;
  logic [19:0] ap3_q;
  logic [31:0] fine3_q;
  // S4
  logic        v4_q, tv4_q;
  logic [19:0] ap4_q;
  logic [31:0] fine4_q, tc4_q, a4_q, q4_q;
  // S5
  logic        v5_q, tv5_q;
  logic [19:0] ap5_q;
  logic [31:0] fine5_q, tc5_q, qq5_q, ap5m_q, a5_q, p4s5_q;
  // S6
  logic        v6_q, tv6_q;
  logic [19:0] ap6_q;
  logic [31:0] fine6_q, tc6_q, b6_q, pa6_q, p2a6_q, p3q6_q;
  // S7
  logic        v7_q, tv7_q;
  logic [19:0] ap7_q;
  logic [31:0] fine7_q, tc7_q, b7_q, a7_q;
  // S8
  logic        v8_q, tv8_q;
  logic [31:0] fine8_q, tc8_q, x8_q, am8_q;
  // S9
  logic        v9_q, tv9_q, bad9_q;
  logic [31:0] fine9_q, tc9_q, x9_q, a9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q} <= '0;
    end else begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q}
        <= {start_i, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q};
    end
  end

  always_ff @(posedge clk_i) begin
    tv1_q <= raw_temp_i != 20'd0;
    ap1_q <= raw_press_i;
    ta1_q <= ((at >> 3) - (t1 << 1)) * t2;
    dd1_q <= dt * dt;

    tv2_q <= tv1_q; ap2_q <= ap1_q;
    ta2_q <= sra32(ta1_q, 11);
    tb2_q <= sra32(dd1_q, 12) * t3;

    tv3_q <= tv2_q; ap3_q <= ap2_q;
    fine3_q <= ta2_q + sra32(tb2_q, 14);

    tv4_q <= tv3_q; ap4_q <= ap3_q; fine4_q <= fine3_q;
    tc4_q <= sra32(fine3_q * 32'd5 + TRnd, 8);
    a4_q  <= sra32(fine3_q, 1) - POff;
    q4_q  <= sra32(sra32(fine3_q, 1) - POff, 2);

    tv5_q <= tv4_q; ap5_q <= ap4_q; fine5_q <= fine4_q; tc5_q <= tc4_q;
    qq5_q  <= q4_q * q4_q;
    ap5m_q <= a4_q * p5;
    a5_q   <= a4_q;
    p4s5_q <= p4 << 16;

    tv6_q <= tv5_q; ap6_q <= ap5_q; fine6_q <= fine5_q; tc6_q <= tc5_q;
    b6_q   <= sra32(qq5_q, 11) * p6;
    pa6_q  <= (ap5m_q << 1) + p4s5_q;
    p2a6_q <= p2 * a5_q;
    p3q6_q <= p3 * sra32(qq5_q, 13);

    tv7_q <= tv6_q; ap7_q <= ap6_q; fine7_q <= fine6_q; tc7_q <= tc6_q;
    b7_q <= sra32(b6_q + (pa6_q - (p4 << 16)), 2) + (p4 << 16);
    a7_q <= sra32(sra32(p3q6_q, 3) + sra32(p2a6_q, 1), 18);

    tv8_q <= tv7_q; fine8_q <= fine7_q; tc8_q <= tc7_q;
    x8_q  <= (PBase - {12'd0, ap7_q}) - sra32(b7_q, 12);
    am8_q <= (POne + a7_q) * p1;

    tv9_q <= tv8_q; fine9_q <= fine8_q; tc9_q <= tc8_q;
    x9_q   <= x8_q * PScale;
    a9_q   <= sra32(am8_q, 15);
    bad9_q <= sra32(am8_q, 15) == 32'd0;
  end

  // divide: small numerator uses (p<<1)/a, otherwise (p/a)*2
  logic        small9;
  logic [31:0] num9, den9;
  assign small9 = x9_q < PHalf;
  assign num9   = small9 ? (x9_q << 1) : x9_q;
  assign den9   = bad9_q ? 32'd1 : a9_q;

  localparam int unsigned SideW = 32 + 32 + 3;
  logic             dv_o;
  logic [31:0]      quo;
  logic [SideW-1:0] side;

  bsc_div #(.SideW(SideW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (v9_q),
    .num_i  (num9),
    .den_i  (den9),
    .side_i ({fine9_q, tc9_q, tv9_q, bad9_q, small9}),
    .vld_o  (dv_o),
    .quo_o  (quo),
    .side_o (side)
  );

  logic [31:0] fine_d, tc_d;
  logic        tv_d, bad_d, small_d;
  assign {fine_d, tc_d, tv_d, bad_d, small_d} = side;

  // S10: q products
  logic        v10_q, tv10_q, bad10_q;
  logic [31:0] fine10_q, tc10_q, p10_q, q10_q, pb10_q;
  logic [31:0] pdiv, p3sq;
  assign pdiv = small_d ? quo : (quo << 1);
  assign p3sq = (pdiv >> 3) * (pdiv >> 3);

  // S11
  logic        v11_q, tv11_q, bad11_q;
  logic [31:0] fine11_q, tc11_q, p11_q, a11_q, b11_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v10_q  <= 1'b0;
      v11_q  <= 1'b0;
      done_o <= 1'b0;
    end else begin
      v10_q  <= dv_o;
      v11_q  <= v10_q;
      done_o <= v11_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tv10_q <= tv_d; bad10_q <= bad_d; fine10_q <= fine_d; tc10_q <= tc_d;
    p10_q  <= pdiv;
    q10_q  <= p3sq >> 13;
    pb10_q <= (pdiv >> 2) * p8;

    tv11_q <= tv10_q; bad11_q <= bad10_q; fine11_q <= fine10_q; tc11_q <= tc10_q;
    p11_q <= p10_q;
    a11_q <= sra32(p9 * q10_q, 12);
    b11_q <= sra32(pb10_q, 13);

    temp_centi_o    <= tc11_q;
    fine_temp_o     <= fine11_q;
    temp_valid_o    <= tv11_q;
    press_invalid_o <= bad11_q;
    press_pa_o      <= bad11_q ? 32'd0 : p11_q + sra32(a11_q + b11_q + p7, 4);
  end

endmodule
